// ----- rtl/blpq_pkg.sv -----
package blpq_pkg;

    localparam int COORD_BITS = 12;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [1:0] CORNER_ORIGIN = 2'd0;
    localparam logic [1:0] CORNER_RIGHT  = 2'd1;
    localparam logic [1:0] CORNER_UPPER  = 2'd2;
    localparam logic [1:0] CORNER_UP     = 2'd3;

endpackage

// ----- rtl/bresenham_line_pixel_quads.sv -----
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    opcode, start_x, start_y, end_x, end_y
// out      out  out_valid / out_stall  corner_x, corner_y, corner_index, last, done_res
//
// Load: no result. Step: four corners on consecutive cycles while out_stall is low (one when done),
//   first corner the cycle after the transfer; one output register holds the corners in turn.
// The next item is taken in the cycle the final corner of the previous one leaves.
// Error update (add/subtract and two compares) happens at the input transfer.
// rst_n clears the line state and the output valid; a step before any load is done.
// in_stall: output holds a corner that is not the final one, or the final one is stalled.
module bresenham_line_pixel_quads #(
    parameter int COORD_BITS = blpq_pkg::COORD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS:0]   corner_x,
    output logic [COORD_BITS:0]   corner_y,
    output logic [1:0]            corner_index,
    output logic                  last,
    output logic                  done_res
);

    localparam int EW = COORD_BITS + 2;   // error term width
    localparam int SW = COORD_BITS + 3;   // width for 2*err compares

    logic [COORD_BITS-1:0] cur_x_reg, cur_y_reg, target_x_reg, target_y_reg;
    logic [COORD_BITS-1:0] delta_x_reg, delta_y_reg;
    logic signed [EW-1:0]  error_term_reg;
    logic                  dir_x_neg_reg, dir_y_neg_reg;

    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic                  out_valid_reg;
    logic [COORD_BITS:0]   corner_x_reg, corner_y_reg;
    logic [1:0]            corner_index_reg;
    logic                  last_reg, done_reg;

    logic in_xfer, out_xfer, at_target;
    logic signed [SW-1:0] e2, dx_s, dy_s, err_sum;
    logic step_x, step_y;
    logic [1:0] idx_next;
    logic [COORD_BITS:0] cx_next, cy_next;

    assign out_xfer  = out_valid_reg && !out_stall;
    assign in_stall  = out_valid_reg && !(last_reg && !out_stall);
    assign in_xfer   = in_valid && !in_stall;
    assign at_target = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);

    always_comb
    begin
        dx_s    = signed'({3'b000, delta_x_reg});
        dy_s    = signed'({3'b000, delta_y_reg});
        e2      = SW'(error_term_reg) <<< 1;
        step_x  = e2 > -dy_s;
        step_y  = e2 < dx_s;
        err_sum = SW'(error_term_reg) - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
    end

    // corner following the one in the output register
    always_comb
    begin
        idx_next = corner_index_reg + 2'd1;
        cx_next  = {1'b0, px_reg};
        cy_next  = {1'b0, py_reg};
        if (idx_next inside {blpq_pkg::CORNER_RIGHT, blpq_pkg::CORNER_UPPER})
        begin
            cx_next = {1'b0, px_reg} + 1'b1;
        end
        if (idx_next inside {blpq_pkg::CORNER_UPPER, blpq_pkg::CORNER_UP})
        begin
            cy_next = {1'b0, py_reg} + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            error_term_reg <= '0;
            dir_x_neg_reg  <= 1'b0;
            dir_y_neg_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (in_xfer && opcode == blpq_pkg::OP_LOAD)
        begin
            cur_x_reg      <= start_x;
            cur_y_reg      <= start_y;
            target_x_reg   <= end_x;
            target_y_reg   <= end_y;
            dir_x_neg_reg  <= !(start_x < end_x);
            dir_y_neg_reg  <= !(start_y < end_y);
            delta_x_reg    <= (end_x >= start_x) ? end_x - start_x : start_x - end_x;
            delta_y_reg    <= (end_y >= start_y) ? end_y - start_y : start_y - end_y;
            error_term_reg <= EW'(signed'({2'b00, (end_x >= start_x) ? end_x - start_x
                                                                     : start_x - end_x}))
                            - EW'(signed'({2'b00, (end_y >= start_y) ? end_y - start_y
                                                                     : start_y - end_y}));
            out_valid_reg  <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
            if (!at_target)
            begin
                error_term_reg <= EW'(err_sum);
                if (step_x)
                begin
                    cur_x_reg <= dir_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
                if (step_y)
                begin
                    cur_y_reg <= dir_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
            end
        end
        else if (out_xfer && last_reg)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer && opcode == blpq_pkg::OP_STEP)
        begin
            px_reg           <= cur_x_reg;
            py_reg           <= cur_y_reg;
            corner_index_reg <= blpq_pkg::CORNER_ORIGIN;
            corner_x_reg     <= at_target ? '0 : {1'b0, cur_x_reg};
            corner_y_reg     <= at_target ? '0 : {1'b0, cur_y_reg};
            last_reg         <= at_target;
            done_reg         <= at_target;
        end
        else if (out_xfer && !last_reg)
        begin
            corner_index_reg <= idx_next;
            corner_x_reg     <= cx_next;
            corner_y_reg     <= cy_next;
            last_reg         <= (idx_next == blpq_pkg::CORNER_UP);
        end
    end

    assign out_valid    = out_valid_reg;
    assign corner_x     = corner_x_reg;
    assign corner_y     = corner_y_reg;
    assign corner_index = corner_index_reg;
    assign last         = last_reg;
    assign done_res     = done_reg;

`ifndef ASSERT_OFF
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> last_reg && corner_x_reg == '0 && corner_y_reg == '0)
        else $error("done result malformed");

    a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg && !out_stall |=>
            out_valid_reg && corner_index_reg == $past(corner_index_reg) + 2'd1)
        else $error("corner sequence broken");

    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && opcode == blpq_pkg::OP_STEP |=>
            out_valid_reg && corner_index_reg == blpq_pkg::CORNER_ORIGIN)
        else $error("step did not start at origin corner");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg && corner_index_reg == blpq_pkg::CORNER_UP |-> last_reg)
        else $error("last flag missing on final corner");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> in_stall)
        else $error("input taken while corners pending");
`endif

endmodule
